[design/qte_pkg.sv]
// Shared types, constants and helper functions for the quaternion to Euler angle block.
package qte_pkg;

  localparam int ANGLE_FRAC_BITS = 7;

  localparam int COMP_W       = 32;
  localparam int Q_W          = 31;
  localparam int P_W          = 2 * Q_W;
  localparam int T_W          = 64;
  localparam int M_W          = 63;
  localparam int R_W          = 31;
  localparam int NORM_MSB     = 29;
  localparam int SQ_BITS      = R_W - 1;
  localparam int REM_W        = 2 * SQ_BITS;
  localparam int CORDIC_STEPS = 24;
  localparam int ACC_FRAC     = 20;
  localparam int Z_W          = 32;
  localparam int XY_W         = 34;
  localparam int ROOT_LAT     = SQ_BITS + 2;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

  localparam int PITCH_FIELD_MAX = 16383;
  localparam int ROT_FIELD_MAX   = 32767;
  localparam int PITCH_LIM = ((90 << ANGLE_FRAC_BITS) > PITCH_FIELD_MAX) ?
                             PITCH_FIELD_MAX : (90 << ANGLE_FRAC_BITS);
  localparam int ROT_LIM   = ((180 << ANGLE_FRAC_BITS) > ROT_FIELD_MAX) ?
                             ROT_FIELD_MAX : (180 << ANGLE_FRAC_BITS);

  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(90 * (1 << ACC_FRAC));
  localparam logic signed [Z_W-1:0] ROUND_HALF =
    Z_W'(1 << (ACC_FRAC - 1 - ANGLE_FRAC_BITS));

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7
  };

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_w;
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
    logic               zero_length;
  } out_t;

  typedef struct packed {
    logic               zero;
    logic signed [Q_W-1:0] w;
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic               zero;
    logic signed [R_W-1:0] pitch_y;
    logic signed [R_W-1:0] pitch_n;
    logic signed [R_W-1:0] roll_y;
    logic signed [R_W-1:0] roll_x;
    logic signed [R_W-1:0] yaw_y;
    logic signed [R_W-1:0] yaw_x;
  } terms_t;

  function automatic logic [5:0] msb_pos(input logic [M_W-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < M_W; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  function automatic logic signed [15:0] to_angle(input logic signed [Z_W-1:0] z,
                                                   input int lim);
    logic signed [Z_W-1:0] r;
    logic signed [Z_W-1:0] l;
    l = Z_W'(lim);
    r = (z + ROUND_HALF) >>> (ACC_FRAC - ANGLE_FRAC_BITS);
    if (r > l) begin
      r = l;
    end else if (r < -l) begin
      r = -l;
    end
    return r[15:0];
  endfunction

endpackage

[design/qte_prescale.sv]
// Prescale stages: component magnitudes, common normalizing shift, signs restored.
module qte_prescale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  qte_pkg::in_t      in_data,
  output logic              out_vld,
  output qte_pkg::quat_t    out_q
);

  logic [qte_pkg::COMP_W-1:0] comp [4];
  logic [qte_pkg::COMP_W-1:0] mag_nxt [4];
  logic [qte_pkg::COMP_W-1:0] m01, m23, max_nxt;

  logic                       vld1_r;
  logic [3:0]                 neg1_r;
  logic [qte_pkg::COMP_W-1:0] mag1_r [4];
  logic [qte_pkg::COMP_W-1:0] max1_r;
  logic                       zero1_r;

  logic [5:0]                 sh;
  logic [qte_pkg::Q_W-1:0]    q_nxt [4];

  logic                       vld2_r;
  qte_pkg::quat_t             q2_r;

  assign comp[0] = in_data.quat_w;
  assign comp[1] = in_data.quat_x;
  assign comp[2] = in_data.quat_y;
  assign comp[3] = in_data.quat_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_nxt[i] = comp[i][qte_pkg::COMP_W-1] ? (~comp[i] + 1'b1) : comp[i];
    end
    m01     = (mag_nxt[0] > mag_nxt[1]) ? mag_nxt[0] : mag_nxt[1];
    m23     = (mag_nxt[2] > mag_nxt[3]) ? mag_nxt[2] : mag_nxt[3];
    max_nxt = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    for (int i = 0; i < 4; i++) begin
      neg1_r[i] <= comp[i][qte_pkg::COMP_W-1];
      mag1_r[i] <= mag_nxt[i];
    end
    max1_r  <= max_nxt;
    zero1_r <= (max_nxt == '0);
  end

  always_comb begin
    logic [qte_pkg::COMP_W-1:0] sm;
    sh = qte_pkg::msb_pos(qte_pkg::M_W'(max1_r));
    for (int i = 0; i < 4; i++) begin
      if (sh >= 6'(qte_pkg::NORM_MSB)) begin
        sm = mag1_r[i] >> (sh - 6'(qte_pkg::NORM_MSB));
      end else begin
        sm = mag1_r[i] << (6'(qte_pkg::NORM_MSB) - sh);
      end
      q_nxt[i] = neg1_r[i] ? -{1'b0, sm[qte_pkg::Q_W-2:0]} : {1'b0, sm[qte_pkg::Q_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    q2_r.zero <= zero1_r;
    q2_r.w    <= q_nxt[0];
    q2_r.x    <= q_nxt[1];
    q2_r.y    <= q_nxt[2];
    q2_r.z    <= q_nxt[3];
  end

  assign out_vld = vld2_r;
  assign out_q   = q2_r;

endmodule

[design/qte_terms.sv]
// Rotation term stages: products, sums, pitch clamp and common reduction of each pair.
module qte_terms (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  qte_pkg::quat_t    in_q,
  output logic              out_vld,
  output qte_pkg::terms_t   out_terms
);

  function automatic logic [qte_pkg::M_W-1:0] mag_of(input logic signed [qte_pkg::T_W-1:0] v);
    logic signed [qte_pkg::T_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[qte_pkg::M_W-1:0];
  endfunction

  function automatic logic signed [qte_pkg::R_W-1:0] reduce(input logic [qte_pkg::M_W-1:0] m,
                                                           input logic neg,
                                                           input logic [5:0] s);
    logic [qte_pkg::M_W-1:0] sm;
    logic signed [qte_pkg::R_W-1:0] r;
    sm = m >> s;
    r  = {1'b0, sm[qte_pkg::R_W-2:0]};
    return neg ? -r : r;
  endfunction

  function automatic logic [5:0] shift_of(input logic [qte_pkg::M_W-1:0] m);
    logic [5:0] p;
    p = qte_pkg::msb_pos(m);
    return (p > 6'(qte_pkg::NORM_MSB)) ? (p - 6'(qte_pkg::NORM_MSB)) : 6'd0;
  endfunction

  // products
  logic vld1_r, zero1_r;
  logic signed [qte_pkg::P_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, wy_r, xz_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    zero1_r <= in_q.zero;
    ww_r <= in_q.w * in_q.w;
    xx_r <= in_q.x * in_q.x;
    yy_r <= in_q.y * in_q.y;
    zz_r <= in_q.z * in_q.z;
    xy_r <= in_q.x * in_q.y;
    wz_r <= in_q.w * in_q.z;
    wy_r <= in_q.w * in_q.y;
    xz_r <= in_q.x * in_q.z;
    yz_r <= in_q.y * in_q.z;
    wx_r <= in_q.w * in_q.x;
  end

  // sums
  logic vld2_r, zero2_r;
  logic signed [qte_pkg::T_W-1:0] n2_r, t0_r, t1_r, t2_r, t3_r, t4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    zero2_r <= zero1_r;
    n2_r <= qte_pkg::T_W'(ww_r) + qte_pkg::T_W'(xx_r) + qte_pkg::T_W'(yy_r) + qte_pkg::T_W'(zz_r);
    t0_r <= qte_pkg::T_W'(ww_r) + qte_pkg::T_W'(xx_r) - qte_pkg::T_W'(yy_r) - qte_pkg::T_W'(zz_r);
    t1_r <= (qte_pkg::T_W'(xy_r) + qte_pkg::T_W'(wz_r)) <<< 1;
    t2_r <= (qte_pkg::T_W'(wy_r) - qte_pkg::T_W'(xz_r)) <<< 1;
    t3_r <= (qte_pkg::T_W'(yz_r) + qte_pkg::T_W'(wx_r)) <<< 1;
    t4_r <= qte_pkg::T_W'(ww_r) - qte_pkg::T_W'(xx_r) - qte_pkg::T_W'(yy_r) + qte_pkg::T_W'(zz_r);
  end

  // clamp and magnitudes
  logic signed [qte_pkg::T_W-1:0] t2c;
  logic [qte_pkg::M_W-1:0] m3, m4, m1, m0;

  always_comb begin
    if (t2_r > n2_r) begin
      t2c = n2_r;
    end else if (t2_r < -n2_r) begin
      t2c = -n2_r;
    end else begin
      t2c = t2_r;
    end
    m3 = mag_of(t3_r);
    m4 = mag_of(t4_r);
    m1 = mag_of(t1_r);
    m0 = mag_of(t0_r);
  end

  logic vld3_r, zero3_r;
  logic [5:0] neg3_r;
  logic [qte_pkg::M_W-1:0] pm_y_r, pm_n_r, rm_y_r, rm_x_r, ym_y_r, ym_x_r, rmax_r, ymax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    zero3_r <= zero2_r;
    neg3_r  <= {t2c[qte_pkg::T_W-1], n2_r[qte_pkg::T_W-1], t3_r[qte_pkg::T_W-1],
                t4_r[qte_pkg::T_W-1], t1_r[qte_pkg::T_W-1], t0_r[qte_pkg::T_W-1]};
    pm_y_r  <= mag_of(t2c);
    pm_n_r  <= mag_of(n2_r);
    rm_y_r  <= m3;
    rm_x_r  <= m4;
    ym_y_r  <= m1;
    ym_x_r  <= m0;
    rmax_r  <= (m3 > m4) ? m3 : m4;
    ymax_r  <= (m1 > m0) ? m1 : m0;
  end

  // pair reduction
  logic [5:0] ps, rs, ys;
  logic vld4_r;
  qte_pkg::terms_t t4s_r;

  always_comb begin
    ps = shift_of(pm_n_r);
    rs = shift_of(rmax_r);
    ys = shift_of(ymax_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    t4s_r.zero    <= zero3_r;
    t4s_r.pitch_y <= reduce(pm_y_r, neg3_r[5], ps);
    t4s_r.pitch_n <= reduce(pm_n_r, neg3_r[4], ps);
    t4s_r.roll_y  <= reduce(rm_y_r, neg3_r[3], rs);
    t4s_r.roll_x  <= reduce(rm_x_r, neg3_r[2], rs);
    t4s_r.yaw_y   <= reduce(ym_y_r, neg3_r[1], ys);
    t4s_r.yaw_x   <= reduce(ym_x_r, neg3_r[0], ys);
  end

  assign out_vld   = vld4_r;
  assign out_terms = t4s_r;

endmodule

[design/qte_root.sv]
// Pitch root pipeline: (n - t)(n + t) and its floor square root, one result bit per stage.
module qte_root (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [qte_pkg::R_W-1:0]     in_n,
  input  logic signed [qte_pkg::R_W-1:0]     in_y,
  output logic                               out_vld,
  output logic [qte_pkg::SQ_BITS-1:0]        out_root
);

  logic signed [qte_pkg::R_W:0] diff, sum;
  logic                         vld_a_r;
  logic [qte_pkg::R_W-1:0]      a_r, b_r;
  logic [2*qte_pkg::R_W-1:0]    prod_full;

  logic                         vld_r  [qte_pkg::SQ_BITS+1];
  logic [qte_pkg::REM_W-1:0]    rem_r  [qte_pkg::SQ_BITS+1];
  logic [qte_pkg::SQ_BITS-1:0]  root_r [qte_pkg::SQ_BITS+1];

  assign diff      = (qte_pkg::R_W+1)'(in_n) - (qte_pkg::R_W+1)'(in_y);
  assign sum       = (qte_pkg::R_W+1)'(in_n) + (qte_pkg::R_W+1)'(in_y);
  assign prod_full = a_r * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      vld_a_r  <= in_vld;
      vld_r[0] <= vld_a_r;
    end
    a_r       <= diff[qte_pkg::R_W-1:0];
    b_r       <= sum[qte_pkg::R_W-1:0];
    rem_r[0]  <= prod_full[qte_pkg::REM_W-1:0];
    root_r[0] <= '0;
  end

  for (genvar s = 0; s < qte_pkg::SQ_BITS; s++) begin : g_stage
    localparam int B = qte_pkg::SQ_BITS - 1 - s;
    logic [qte_pkg::REM_W:0] trial;
    logic                    fits;

    always_comb begin
      trial = ((qte_pkg::REM_W+1)'(root_r[s]) << (B + 1)) |
              ((qte_pkg::REM_W+1)'(1) << (2 * B));
      fits  = ({1'b0, rem_r[s]} >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rem_r[s+1]  <= fits ? (rem_r[s] - trial[qte_pkg::REM_W-1:0]) : rem_r[s];
      root_r[s+1] <= fits ? (root_r[s] | (qte_pkg::SQ_BITS'(1) << B)) : root_r[s];
    end
  end

  assign out_vld  = vld_r[qte_pkg::SQ_BITS];
  assign out_root = root_r[qte_pkg::SQ_BITS];

endmodule

[design/qte_cordic.sv]
// Pipelined vectoring CORDIC for atan2, one rotation step per stage.
module qte_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [qte_pkg::R_W-1:0] in_y,
  input  logic signed [qte_pkg::R_W-1:0] in_x,
  output logic                           out_vld,
  output logic signed [qte_pkg::Z_W-1:0] out_z
);

  localparam int N = qte_pkg::CORDIC_STEPS;

  logic                            vld_r  [N+1];
  logic                            zero_r [N+1];
  logic signed [qte_pkg::XY_W-1:0] x_r    [N+1];
  logic signed [qte_pkg::XY_W-1:0] y_r    [N+1];
  logic signed [qte_pkg::Z_W-1:0]  z_r    [N+1];

  logic signed [qte_pkg::XY_W-1:0] xe, ye, x0, y0;
  logic signed [qte_pkg::Z_W-1:0]  z0;

  always_comb begin
    xe = qte_pkg::XY_W'(in_x);
    ye = qte_pkg::XY_W'(in_y);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = qte_pkg::QUARTER_TURN;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -qte_pkg::QUARTER_TURN;
      end
    end else begin
      x0 = xe;
      y0 = ye;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    x_r[0]    <= x0;
    y_r[0]    <= y0;
    z_r[0]    <= z0;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [qte_pkg::XY_W-1:0] dx, dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + qte_pkg::ATAN_TAB[i];
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - qte_pkg::ATAN_TAB[i];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_z   = zero_r[N] ? '0 : z_r[N];

endmodule

[design/quaternion_to_euler_angles_top.sv]
// Quaternion to Euler angles: pitch, roll and yaw in 1/128 degree from one quaternion.
// Path from accepted start to out_valid: prescale, terms, root, CORDIC and the output
// register; the root pipeline sets the depth.
// Throughput: one item per cycle; busy stays low, so start is always taken.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
// Results come as a one-cycle out_valid strobe and cannot be stalled.
module quaternion_to_euler_angles_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  qte_pkg::in_t   in_data,
  output logic           out_valid,
  output qte_pkg::out_t  out_data
);

  typedef struct packed {
    logic                           zero;
    logic signed [qte_pkg::R_W-1:0] pitch_y;
    logic signed [qte_pkg::R_W-1:0] roll_y;
    logic signed [qte_pkg::R_W-1:0] roll_x;
    logic signed [qte_pkg::R_W-1:0] yaw_y;
    logic signed [qte_pkg::R_W-1:0] yaw_x;
  } side_t;

  logic                               q_vld;
  qte_pkg::quat_t                     q;
  logic                               t_vld;
  qte_pkg::terms_t                    terms;
  logic                               root_vld;
  logic [qte_pkg::SQ_BITS-1:0]        root;

  side_t                              side_r [qte_pkg::ROOT_LAT];
  logic                               zero_dly_r [qte_pkg::CORDIC_LAT];
  side_t                              side_o;

  logic                               p_vld, r_vld, y_vld;
  logic signed [qte_pkg::Z_W-1:0]     p_z, r_z, y_z;
  logic signed [15:0]                 p_ang;

  logic                               out_valid_r;
  qte_pkg::out_t                      out_data_r;

  assign busy = 1'b0;

  qte_prescale u_prescale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_data (in_data),
    .out_vld (q_vld),
    .out_q   (q)
  );

  qte_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (q_vld),
    .in_q      (q),
    .out_vld   (t_vld),
    .out_terms (terms)
  );

  qte_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (t_vld),
    .in_n     (terms.pitch_n),
    .in_y     (terms.pitch_y),
    .out_vld  (root_vld),
    .out_root (root)
  );

  always_ff @(posedge clk) begin
    side_r[0].zero    <= terms.zero;
    side_r[0].pitch_y <= terms.pitch_y;
    side_r[0].roll_y  <= terms.roll_y;
    side_r[0].roll_x  <= terms.roll_x;
    side_r[0].yaw_y   <= terms.yaw_y;
    side_r[0].yaw_x   <= terms.yaw_x;
    for (int i = 1; i < qte_pkg::ROOT_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
    zero_dly_r[0] <= side_o.zero;
    for (int i = 1; i < qte_pkg::CORDIC_LAT; i++) begin
      zero_dly_r[i] <= zero_dly_r[i-1];
    end
  end

  assign side_o = side_r[qte_pkg::ROOT_LAT-1];

  qte_cordic u_cordic_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (root_vld),
    .in_y    (side_o.pitch_y),
    .in_x    ($signed({1'b0, root})),
    .out_vld (p_vld),
    .out_z   (p_z)
  );

  qte_cordic u_cordic_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (root_vld),
    .in_y    (side_o.roll_y),
    .in_x    (side_o.roll_x),
    .out_vld (r_vld),
    .out_z   (r_z)
  );

  qte_cordic u_cordic_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (root_vld),
    .in_y    (side_o.yaw_y),
    .in_x    (side_o.yaw_x),
    .out_vld (y_vld),
    .out_z   (y_z)
  );

  assign p_ang = qte_pkg::to_angle(p_z, qte_pkg::PITCH_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p_vld & r_vld & y_vld;
    end
    if (zero_dly_r[qte_pkg::CORDIC_LAT-1]) begin
      out_data_r.pitch_angle <= '0;
      out_data_r.roll_angle  <= '0;
      out_data_r.yaw_angle   <= '0;
      out_data_r.zero_length <= 1'b1;
    end else begin
      out_data_r.pitch_angle <= p_ang[14:0];
      out_data_r.roll_angle  <= qte_pkg::to_angle(r_z, qte_pkg::ROT_LIM);
      out_data_r.yaw_angle   <= qte_pkg::to_angle(y_z, qte_pkg::ROT_LIM);
      out_data_r.zero_length <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[dv/tb_quaternion_to_euler_angles_top.sv]
// Testbench for the quaternion to Euler angle block: random and corner items vs a predictor.
module tb_quaternion_to_euler_angles_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 1500;

  localparam longint ANGLE_TABLE [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  qte_pkg::in_t   in_data;
  logic           out_valid;
  qte_pkg::out_t  out_data;

  qte_pkg::in_t   pending_quats[$];
  qte_pkg::out_t  expected_angles[$];
  int    error_count;
  int    idle_cycles;
  int    gap_left;
  bit    stim_done;

  quaternion_to_euler_angles_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint trunc_shr(longint v, int s);
    if (v < 0) begin
      return -((-v) >>> s);
    end
    return v >>> s;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void shrink_pair(ref longint a, ref longint b);
    longint m;
    int     s;
    m = abs64(a);
    s = 0;
    if (abs64(b) > m) begin
      m = abs64(b);
    end
    while (s < 63 && (m >>> s) >= (64'sd1 <<< 30)) begin
      s++;
    end
    a = trunc_shr(a, s);
    b = trunc_shr(b, s);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) begin
      bitv >>= 2;
    end
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd90 <<< 20;
      end else begin
        x = -y; y = t; z = -(64'sd90 <<< 20);
      end
    end
    for (int i = 0; i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ANGLE_TABLE[i];
      end else begin
        x -= dx; y += dy; z -= ANGLE_TABLE[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_clamp(longint z, longint deg, longint field_max);
    longint r;
    longint lim;
    r = floor_shr(z + (64'sd1 <<< (19 - qte_pkg::ANGLE_FRAC_BITS)),
                  20 - qte_pkg::ANGLE_FRAC_BITS);
    lim = deg <<< qte_pkg::ANGLE_FRAC_BITS;
    if (lim > field_max) begin
      lim = field_max;
    end
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  function automatic qte_pkg::out_t predict_angles(qte_pkg::in_t q);
    qte_pkg::out_t    res;
    longint           comp[4];
    longint unsigned  mag[4];
    longint unsigned  mx;
    int               left;
    int               right;
    longint           w, x, y, z, n, t0, t1, t2, t3, t4, a, b, r;
    comp[0] = q.quat_w; comp[1] = q.quat_x; comp[2] = q.quat_y; comp[3] = q.quat_z;
    mx = 0;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (comp[i] < 0) ? longint'(-comp[i]) : comp[i];
      if (mag[i] > mx) begin
        mx = mag[i];
      end
    end
    if (mx == 0) begin
      res.zero_length = 1'b1;
      return res;
    end
    left = 0;
    right = 0;
    while ((mx >> right) >= (64'd1 << 30)) begin
      right++;
    end
    while ((mx << left) < (64'd1 << 29)) begin
      left++;
    end
    for (int i = 0; i < 4; i++) begin
      mag[i] = (mag[i] >> right) << left;
      comp[i] = (comp[i] < 0) ? -longint'(mag[i]) : longint'(mag[i]);
    end
    w = comp[0]; x = comp[1]; y = comp[2]; z = comp[3];
    n  = w*w + x*x + y*y + z*z;
    t0 = w*w + x*x - y*y - z*z;
    t1 = 2 * (x*y + w*z);
    t2 = 2 * (w*y - x*z);
    t3 = 2 * (y*z + w*x);
    t4 = w*w - x*x - y*y + z*z;
    if (t2 > n) begin
      t2 = n;
    end
    if (t2 < -n) begin
      t2 = -n;
    end
    shrink_pair(t2, n);
    a = n - t2;
    b = n + t2;
    r = int_sqrt(longint'(a) * longint'(b));
    res.pitch_angle = 15'(round_clamp(vector_angle(t2, r), 90, 16383));
    shrink_pair(t3, t4);
    res.roll_angle = 16'(round_clamp(vector_angle(t3, t4), 180, 32767));
    shrink_pair(t1, t0);
    res.yaw_angle = 16'(round_clamp(vector_angle(t1, t0), 180, 32767));
    return res;
  endfunction

  function automatic logic [31:0] rand_component();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 6)) - 32'd3;
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic qte_pkg::in_t make_quat(logic [31:0] w, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z);
    qte_pkg::in_t q;
    q.quat_w = w; q.quat_x = x; q.quat_y = y; q.quat_z = z;
    return q;
  endfunction

  initial begin
    logic [31:0] s;
    error_count = 0;
    stim_done = 1'b0;
    pending_quats.push_back(make_quat(0, 0, 0, 0));
    pending_quats.push_back(make_quat(1, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 1, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 1, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 1));
    pending_quats.push_back(make_quat(-1, 0, 0, 0));
    pending_quats.push_back(make_quat(32'h8000_0000, 0, 0, 0));
    pending_quats.push_back(make_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF));
    pending_quats.push_back(make_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000));
    pending_quats.push_back(make_quat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF));
    // gimbal lock: pitch term at the clamp limits
    pending_quats.push_back(make_quat(1000, 0, 1000, 0));
    pending_quats.push_back(make_quat(1000, 0, -1000, 0));
    pending_quats.push_back(make_quat(1000, -1000, 1000, 1000));
    pending_quats.push_back(make_quat(0, 32'h7FFF_FFFF, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 32'h8000_0000));
    pending_quats.push_back(make_quat(0, 1, 1, 0));
    pending_quats.push_back(make_quat(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                                      32'hFFFF_0000));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      s = $urandom;
      if (s[2:0] == 3'd0) begin
        pending_quats.push_back(make_quat(rand_component(), rand_component(),
                                          rand_component(), rand_component()));
      end else begin
        pending_quats.push_back(make_quat($urandom, $urandom, $urandom, $urandom));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_angles.push_back(predict_angles(in_data));
      end
      if (start && busy) begin
        // hold until taken
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_quats.size() > 0) begin
        start <= 1'b1;
        in_data <= pending_quats.pop_front();
        if ($urandom_range(0, 3) == 0) begin
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 3);
        end
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    qte_pkg::out_t exp_item;
    if (rst_n && out_valid) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        exp_item = expected_angles.pop_front();
        if (out_data.pitch_angle !== exp_item.pitch_angle) begin
          $display("%0t: pitch expected %0d actual %0d", $time,
                   exp_item.pitch_angle, out_data.pitch_angle);
          error_count++;
        end
        if (out_data.roll_angle !== exp_item.roll_angle) begin
          $display("%0t: roll expected %0d actual %0d", $time,
                   exp_item.roll_angle, out_data.roll_angle);
          error_count++;
        end
        if (out_data.yaw_angle !== exp_item.yaw_angle) begin
          $display("%0t: yaw expected %0d actual %0d", $time,
                   exp_item.yaw_angle, out_data.yaw_angle);
          error_count++;
        end
        if (out_data.zero_length !== exp_item.zero_length) begin
          $display("%0t: zero_length expected %0b actual %0b", $time,
                   exp_item.zero_length, out_data.zero_length);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (out_valid === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done && expected_angles.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
